// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMI_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SMI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SMI_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== sv/smi_pkg.sv =====
// Shared types and constants of the small matrix inverse unit.
package smi_pkg;

   typedef enum logic [1:0] {
      ORDER_1 = 2'd1,
      ORDER_2 = 2'd2,
      ORDER_3 = 2'd3
   } order_type;

   localparam logic [1:0] CSR_ORDER  = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;

   localparam int THRESH_BITS = 48;

   typedef struct packed {
      logic valid;
      logic neg;
      logic kill;
   } lane_ctl_type;

endpackage

// ===== sv/smi_divider.sv =====
// Pipelined restoring divider of a numerator that carries its rounding offset, with sign and saturation.
module smi_divider #(
   parameter int WORD_BITS = 32,
   parameter int NUM_BITS  = 170,
   parameter int DEN_BITS  = 99
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  smi_pkg::lane_ctl_type       in_ctl,
   input  logic [NUM_BITS-1:0]         n_in,
   input  logic [DEN_BITS-1:0]         d_in,
   output smi_pkg::lane_ctl_type       out_ctl,
   output logic [WORD_BITS-1:0]        q_out
);
   import smi_pkg::*;

   localparam int W = WORD_BITS;

   lane_ctl_type          ctl_ff  [0:W];
   logic [DEN_BITS-1:0]   rem_ff  [0:W];
   logic [DEN_BITS-1:0]   d_ff    [0:W];
   logic [W-1:0]          nlow_ff [0:W];
   logic [W-1:0]          q_ff    [0:W];
   logic                  ovf_ff  [0:W];

   lane_ctl_type          res_ctl_ff;
   logic [W-1:0]          res_ff;

   logic                  ovf_in;
   logic [W-1:0]          lim;
   logic [W-1:0]          mag;
   logic [W-1:0]          res_in;

   assign ovf_in = ({{DEN_BITS{1'b0}}, n_in} >> W) >= {{NUM_BITS{1'b0}}, d_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
      end
      if (en) begin
         rem_ff[0]  <= DEN_BITS'(n_in >> W);
         d_ff[0]    <= d_in;
         nlow_ff[0] <= n_in[W-1:0];
         q_ff[0]    <= '0;
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar s = 1; s <= W; s++) begin : g_step
      logic [DEN_BITS:0] trial;
      logic              take;

      assign trial = {rem_ff[s-1], nlow_ff[s-1][W-s]};
      assign take  = trial >= {1'b0, d_ff[s-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         if (en) begin
            rem_ff[s]  <= take ? DEN_BITS'(trial - {1'b0, d_ff[s-1]}) : DEN_BITS'(trial);
            q_ff[s]    <= {q_ff[s-1][W-2:0], take};
            d_ff[s]    <= d_ff[s-1];
            nlow_ff[s] <= nlow_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
         end
      end
   end

   always_comb begin
      lim = {1'b0, {(W-1){1'b1}}} + W'(ctl_ff[W].neg);
      mag = (ovf_ff[W] || (q_ff[W] > lim)) ? lim : q_ff[W];
      if (ctl_ff[W].kill) begin
         res_in = '0;
      end else if (ctl_ff[W].neg) begin
         res_in = W'(0) - mag;
      end else begin
         res_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ctl_ff <= '0;
      end else if (en) begin
         res_ctl_ff <= ctl_ff[W];
      end
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_ctl = res_ctl_ff;
   assign q_out   = res_ff;

endmodule

// ===== sv/small_matrix_inverse_unit.sv =====
// Top level of the small matrix inverse unit: cofactor pipeline and dividers.
// One word is accepted per cycle while no result waits; the nine pipelined dividers set the depth.
// The whole pipeline advances together and holds while a result waits.
// Synchronous active-high reset clears all valid bits and sets order 3, threshold 1.
module small_matrix_inverse_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [smi_pkg::THRESH_BITS-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [WORD_BITS-1:0]          req_a00,
   input  logic signed [WORD_BITS-1:0]          req_a01,
   input  logic signed [WORD_BITS-1:0]          req_a02,
   input  logic signed [WORD_BITS-1:0]          req_a10,
   input  logic signed [WORD_BITS-1:0]          req_a11,
   input  logic signed [WORD_BITS-1:0]          req_a12,
   input  logic signed [WORD_BITS-1:0]          req_a20,
   input  logic signed [WORD_BITS-1:0]          req_a21,
   input  logic signed [WORD_BITS-1:0]          req_a22,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [WORD_BITS-1:0]          rsp_inv00,
   output logic signed [WORD_BITS-1:0]          rsp_inv01,
   output logic signed [WORD_BITS-1:0]          rsp_inv02,
   output logic signed [WORD_BITS-1:0]          rsp_inv10,
   output logic signed [WORD_BITS-1:0]          rsp_inv11,
   output logic signed [WORD_BITS-1:0]          rsp_inv12,
   output logic signed [WORD_BITS-1:0]          rsp_inv20,
   output logic signed [WORD_BITS-1:0]          rsp_inv21,
   output logic signed [WORD_BITS-1:0]          rsp_inv22,
   output logic signed [WORD_BITS-1:0]          rsp_det_value,
   output logic                                 rsp_singular
);
   import smi_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;
   localparam int AW   = 2 * W + 1;
   localparam int DETW = 3 * W + 2;
   localparam int DW   = DETW + 1;
   localparam int NW   = ((AW + 2 * F + 1) > DETW ? (AW + 2 * F + 1) : DETW) + 1;
   localparam int CW   = DETW > THRESH_BITS ? DETW : THRESH_BITS;

   logic [1:0]              order_ff;
   logic [THRESH_BITS-1:0]  thresh_ff;
   logic                    en;
   order_type               ord_in;

   logic signed [W-1:0]     m_in [3][3];

   // Stage 1: pairwise products.
   logic signed [PW-1:0]    pa_in [3][3];
   logic signed [PW-1:0]    pb_in [3][3];
   logic signed [PW-1:0]    pa1_ff [3][3];
   logic signed [PW-1:0]    pb1_ff [3][3];
   logic signed [W-1:0]     m1_ff [3][3];
   order_type               ord1_ff;
   logic                    v1_ff;

   // Stage 2: adjugate.
   logic signed [AW-1:0]    adj2_in [3][3];
   logic signed [AW-1:0]    adj2_ff [3][3];
   logic signed [AW-1:0]    det2_ff;
   logic signed [W-1:0]     m2_ff [3];
   order_type               ord2_ff;
   logic                    v2_ff;

   // Stage 3: split products for the order 3 expansion.
   logic signed [AW-1:0]    lo3_ff [3];
   logic signed [AW-1:0]    hi3_ff [3];
   logic signed [AW-1:0]    adj3_ff [3][3];
   logic signed [AW-1:0]    det3_ff;
   logic signed [W-1:0]     m003_ff;
   order_type               ord3_ff;
   logic                    v3_ff;

   // Stage 4: exact determinant.
   logic signed [DETW-1:0]  det4_in;
   logic signed [DETW-1:0]  det4_ff;
   logic signed [AW-1:0]    adj4_ff [3][3];
   order_type               ord4_ff;
   logic                    v4_ff;

   // Stage 5: magnitudes.
   logic [DETW-1:0]         dmag5_ff;
   logic                    dneg5_ff;
   logic [AW-1:0]           amag5_ff [3][3];
   logic                    aneg5_ff [3][3];
   order_type               ord5_ff;
   logic                    v5_ff;

   // Stage 6: singular test, rounding, divider operands.
   logic                    sing6_in;
   logic [DETW:0]           half6;
   logic [DETW:0]           rq6_in;
   logic [DETW:0]           rq6_ff;
   logic                    sing6_ff;
   logic                    dneg6_ff;
   logic [NW-1:0]           num6_ff [3][3];
   logic [DW-1:0]           den6_ff;
   lane_ctl_type            ctl6_ff [3][3];

   // Determinant delay line, matched to the divider depth.
   logic [W-1:0]            dlim;
   logic [W-1:0]            dmagw;
   logic [W-1:0]            dval_in;
   logic [W-1:0]            dval_ff [0:W+1];
   logic                    dsing_ff [0:W+1];

   lane_ctl_type            out_ctl [3][3];
   logic [W-1:0]            q_out [3][3];

   assign csr_ready = 1'b1;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= 2'd3;
         thresh_ff <= THRESH_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORDER:  order_ff  <= csr_data[1:0];
            CSR_THRESH: thresh_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   assign ord_in = (order_ff == 2'd0) ? ORDER_1 : order_type'(order_ff);

   assign m_in[0][0] = req_a00;
   assign m_in[0][1] = req_a01;
   assign m_in[0][2] = req_a02;
   assign m_in[1][0] = req_a10;
   assign m_in[1][1] = req_a11;
   assign m_in[1][2] = req_a12;
   assign m_in[2][0] = req_a20;
   assign m_in[2][1] = req_a21;
   assign m_in[2][2] = req_a22;

   for (genvar i = 0; i < 3; i++) begin : g_pr
      for (genvar j = 0; j < 3; j++) begin : g_pc
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         assign pa_in[i][j] = m_in[I1][J1] * m_in[I2][J2];
         assign pb_in[i][j] = m_in[I1][J2] * m_in[I2][J1];
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            adj2_in[r][c] = '0;
         end
      end
      case (ord1_ff)
         ORDER_1: begin
            adj2_in[0][0] = AW'(1);
         end
         ORDER_2: begin
            adj2_in[0][0] = AW'(m1_ff[1][1]);
            adj2_in[0][1] = -AW'(m1_ff[0][1]);
            adj2_in[1][0] = -AW'(m1_ff[1][0]);
            adj2_in[1][1] = AW'(m1_ff[0][0]);
         end
         default: begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  adj2_in[r][c] = AW'(pa1_ff[c][r]) - AW'(pb1_ff[c][r]);
               end
            end
         end
      endcase
   end

   always_comb begin
      case (ord3_ff)
         ORDER_1: det4_in = DETW'(m003_ff);
         ORDER_2: det4_in = DETW'(det3_ff);
         default: begin
            det4_in = '0;
            for (int k = 0; k < 3; k++) begin
               det4_in = det4_in + (DETW'(hi3_ff[k]) <<< W) + DETW'(lo3_ff[k]);
            end
         end
      endcase
   end

   always_comb begin
      sing6_in = (dmag5_ff == '0) || (CW'(dmag5_ff) < CW'(thresh_ff));
      case (ord5_ff)
         ORDER_1: half6 = '0;
         ORDER_2: half6 = (DETW + 1)'(1) << (F - 1);
         default: half6 = (DETW + 1)'(1) << (2 * F - 1);
      endcase
      case (ord5_ff)
         ORDER_1: rq6_in = {1'b0, dmag5_ff};
         ORDER_2: rq6_in = ({1'b0, dmag5_ff} + half6) >> F;
         default: rq6_in = ({1'b0, dmag5_ff} + half6) >> (2 * F);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         ord1_ff <= ord_in;
         ord2_ff <= ord1_ff;
         ord3_ff <= ord2_ff;
         ord4_ff <= ord3_ff;
         ord5_ff <= ord4_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pa1_ff[r][c] <= pa_in[r][c];
               pb1_ff[r][c] <= pb_in[r][c];
               m1_ff[r][c]  <= m_in[r][c];
               adj2_ff[r][c] <= adj2_in[r][c];
               adj3_ff[r][c] <= adj2_ff[r][c];
               adj4_ff[r][c] <= adj3_ff[r][c];
               aneg5_ff[r][c] <= adj4_ff[r][c][AW-1];
               amag5_ff[r][c] <= adj4_ff[r][c][AW-1] ? AW'(-adj4_ff[r][c]) : AW'(adj4_ff[r][c]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            m2_ff[k]  <= m1_ff[0][k];
            lo3_ff[k] <= AW'(m2_ff[k] * $signed({1'b0, adj2_ff[k][0][W-1:0]}));
            hi3_ff[k] <= AW'(m2_ff[k] * $signed(adj2_ff[k][0][AW-1:W]));
         end
         det2_ff  <= AW'(pa1_ff[2][2]) - AW'(pb1_ff[2][2]);
         det3_ff  <= det2_ff;
         m003_ff  <= m2_ff[0];
         det4_ff  <= det4_in;
         dneg5_ff <= det4_ff[DETW-1];
         dmag5_ff <= det4_ff[DETW-1] ? DETW'(-det4_ff) : DETW'(det4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               ctl6_ff[r][c] <= '0;
            end
         end
      end else if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               ctl6_ff[r][c].valid <= v5_ff;
               ctl6_ff[r][c].neg   <= aneg5_ff[r][c] ^ dneg5_ff;
               ctl6_ff[r][c].kill  <= sing6_in || (2'(r) >= 2'(ord5_ff))
                                      || (2'(c) >= 2'(ord5_ff));
            end
         end
      end
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               num6_ff[r][c] <= (NW'(amag5_ff[r][c]) << (2 * F + 1)) + NW'(dmag5_ff);
            end
         end
         den6_ff  <= DW'(dmag5_ff) << 1;
         rq6_ff   <= rq6_in;
         sing6_ff <= sing6_in;
         dneg6_ff <= dneg5_ff;
      end
   end

   always_comb begin
      dlim    = {1'b0, {(W-1){1'b1}}} + W'(dneg6_ff);
      dmagw   = (rq6_ff > (DETW + 1)'(dlim)) ? dlim : rq6_ff[W-1:0];
      dval_in = dneg6_ff ? W'(0) - dmagw : dmagw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dval_ff[0]  <= dval_in;
         dsing_ff[0] <= sing6_ff;
         for (int k = 1; k <= W + 1; k++) begin
            dval_ff[k]  <= dval_ff[k-1];
            dsing_ff[k] <= dsing_ff[k-1];
         end
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_dr
      for (genvar c = 0; c < 3; c++) begin : g_dc
         smi_divider #(
            .WORD_BITS (W),
            .NUM_BITS  (NW),
            .DEN_BITS  (DW)
         ) u_div (
            .clock   (clock),
            .reset   (reset),
            .en      (en),
            .in_ctl  (ctl6_ff[r][c]),
            .n_in    (num6_ff[r][c]),
            .d_in    (den6_ff),
            .out_ctl (out_ctl[r][c]),
            .q_out   (q_out[r][c])
         );
      end
   end

   assign rsp_valid     = out_ctl[0][0].valid;
   assign rsp_inv00     = q_out[0][0];
   assign rsp_inv01     = q_out[0][1];
   assign rsp_inv02     = q_out[0][2];
   assign rsp_inv10     = q_out[1][0];
   assign rsp_inv11     = q_out[1][1];
   assign rsp_inv12     = q_out[1][2];
   assign rsp_inv20     = q_out[2][0];
   assign rsp_inv21     = q_out[2][1];
   assign rsp_inv22     = q_out[2][2];
   assign rsp_det_value = dval_ff[W+1];
   assign rsp_singular  = dsing_ff[W+1];

endmodule

// ===== sv/smi_checker.sv =====
// Port-level checker for the small matrix inverse unit and its bind.
`include "assert_macros.svh"

module smi_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_singular,
   input logic [WORD_BITS-1:0]  rsp_inv00,
   input logic [WORD_BITS-1:0]  rsp_inv01,
   input logic [WORD_BITS-1:0]  rsp_inv02,
   input logic [WORD_BITS-1:0]  rsp_inv10,
   input logic [WORD_BITS-1:0]  rsp_inv11,
   input logic [WORD_BITS-1:0]  rsp_inv12,
   input logic [WORD_BITS-1:0]  rsp_inv20,
   input logic [WORD_BITS-1:0]  rsp_inv21,
   input logic [WORD_BITS-1:0]  rsp_inv22
);

   logic inv_zero;
   logic stall;

   assign inv_zero = (rsp_inv00 == '0) && (rsp_inv01 == '0) && (rsp_inv02 == '0)
                  && (rsp_inv10 == '0) && (rsp_inv11 == '0) && (rsp_inv12 == '0)
                  && (rsp_inv20 == '0) && (rsp_inv21 == '0) && (rsp_inv22 == '0);
   assign stall = rsp_valid && !rsp_ready;

   `SMI_ASSERT_IMPLY(a_singular_zero, clock, reset, rsp_valid && rsp_singular, inv_zero)
   `SMI_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `SMI_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `SMI_ASSERT_NEXT(a_stall_holds, clock, reset, stall, rsp_valid && $stable(rsp_inv00))

endmodule

bind small_matrix_inverse_unit smi_checker #(
   .WORD_BITS (WORD_BITS)
) u_smi_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_singular (rsp_singular),
   .rsp_inv00    (rsp_inv00),
   .rsp_inv01    (rsp_inv01),
   .rsp_inv02    (rsp_inv02),
   .rsp_inv10    (rsp_inv10),
   .rsp_inv11    (rsp_inv11),
   .rsp_inv12    (rsp_inv12),
   .rsp_inv20    (rsp_inv20),
   .rsp_inv21    (rsp_inv21),
   .rsp_inv22    (rsp_inv22)
);

// ===== test/small_matrix_inverse_unit_test.sv =====
// Self-checking testbench of the small matrix inverse unit with an exact-arithmetic predictor.
module small_matrix_inverse_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import smi_pkg::*;

   localparam int FRAC = 16;
   localparam int WB = 32;
   localparam int LATENCY = WB + 8;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] ORDER_ZERO = 2'd0;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [WB-1:0] elem_type;
   typedef struct packed {
      logic [8:0][WB-1:0] inv;
      logic [WB-1:0] det;
      logic sing;
   } inverse_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [THRESH_BITS-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   elem_type req_a [9];
   logic rsp_valid;
   logic rsp_ready = 0;
   elem_type rsp_inv [9];
   elem_type rsp_det_value;
   logic rsp_singular;

   logic [1:0] cur_order;
   logic [THRESH_BITS-1:0] cur_thresh;
   inverse_type expected_inverses[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;

   initial foreach (req_a[i]) req_a[i] = '0;

   small_matrix_inverse_unit DUT (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_ready,
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid, .rsp_ready,
      .rsp_inv00(rsp_inv[0]), .rsp_inv01(rsp_inv[1]), .rsp_inv02(rsp_inv[2]),
      .rsp_inv10(rsp_inv[3]), .rsp_inv11(rsp_inv[4]), .rsp_inv12(rsp_inv[5]),
      .rsp_inv20(rsp_inv[6]), .rsp_inv21(rsp_inv[7]), .rsp_inv22(rsp_inv[8]),
      .rsp_det_value, .rsp_singular
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[small_matrix_inverse_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [WB-1:0] round_div_sat(input wide_type num, input wide_type den);
      logic neg;
      logic [127:0] n, d, q, lim;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      q = (2 * n + d) / (2 * d);
      lim = neg ? (128'd1 << (WB - 1)) : (128'd1 << (WB - 1)) - 1;
      if (q > lim) q = lim;
      return neg ? WB'(-q) : WB'(q);
   endfunction

   function automatic inverse_type predict_inverse(input elem_type a [9]);
      wide_type m [3][3];
      wide_type adj [3][3];
      wide_type det;
      inverse_type r;
      int n;
      n = (cur_order == ORDER_ZERO) ? 1 : int'(cur_order);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            m[i][j] = wide_type'(a[i * 3 + j]);
            adj[i][j] = '0;
         end
      if (n == 1) begin
         det = m[0][0];
         adj[0][0] = 1;
      end else if (n == 2) begin
         det = m[0][0] * m[1][1] - m[0][1] * m[1][0];
         adj[0][0] = m[1][1];
         adj[0][1] = -m[0][1];
         adj[1][0] = -m[1][0];
         adj[1][1] = m[0][0];
      end else begin
         det = '0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               adj[j][i] = m[(i + 1) % 3][(j + 1) % 3] * m[(i + 2) % 3][(j + 2) % 3]
                         - m[(i + 1) % 3][(j + 2) % 3] * m[(i + 2) % 3][(j + 1) % 3];
         for (int j = 0; j < 3; j++) det = det + m[0][j] * adj[j][0];
      end
      r.sing = (det == 0) || ((det[127] ? -det : det) < wide_type'({80'd0, cur_thresh}));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r.inv[i * 3 + j] = (!r.sing && i < n && j < n) ?
               round_div_sat(adj[i][j] <<< (2 * FRAC), det) : '0;
      r.det = round_div_sat(det, wide_type'(1) <<< ((n - 1) * FRAC));
      return r;
   endfunction

   always @(posedge clock) begin
      inverse_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_inverses.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               e = expected_inverses.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_inv[k] !== e.inv[k]) begin
                     $error("inv%0d%0d expected %h actual %h", k / 3, k % 3, e.inv[k], rsp_inv[k]);
                     errors++;
                  end
               if (rsp_det_value !== e.det) begin
                  $error("det_value expected %h actual %h", e.det, rsp_det_value);
                  errors++;
               end
               if (rsp_singular !== e.sing) begin
                  $error("singular expected %b actual %b", e.sing, rsp_singular);
                  errors++;
               end
            end
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 34);
      end
   end

   task automatic send_matrix(input elem_type a [9]);
      if (!quiet) begin
         while ($urandom_range(99) < 34) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      foreach (a[k]) req_a[k] <= a[k];
      do @(posedge clock); while (!req_ready);
      expected_inverses.push_back(predict_inverse(a));
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (expected_inverses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [THRESH_BITS-1:0] value);
      drain_results();
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (index == CSR_ORDER) cur_order = value[1:0];
      else if (index == CSR_THRESH) cur_thresh = value;
      @(posedge clock);
   endtask

   function automatic elem_type random_element(input int kind);
      case (kind)
         0: return elem_type'($urandom);
         1: return elem_type'($urandom_range(0, 262143)) - elem_type'(131072);
         2: return $urandom_range(1) ? elem_type'(32'h7FFFFFFF) : elem_type'(32'h80000000);
         default: return elem_type'($urandom_range(0, 511)) - elem_type'(256);
      endcase
   endfunction

   task automatic send_random(input int count);
      elem_type a [9];
      int kind;
      repeat (count) begin
         kind = $urandom_range(0, 9);
         foreach (a[k])
            a[k] = random_element(kind < 3 ? 0 : kind < 7 ? 1 : kind < 8 ? 2 : $urandom_range(0, 3));
         send_matrix(a);
      end
   endtask

   task automatic test_directed();
      elem_type a [9];
      elem_type one = elem_type'(32'sh10000);
      a = '{one, 0, 0, 0, one, 0, 0, 0, one};
      send_matrix(a);
      a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(a);
      foreach (a[k]) a[k] = elem_type'(32'h7FFFFFFF);
      send_matrix(a);
      foreach (a[k]) a[k] = elem_type'(32'h80000000);
      send_matrix(a);
      a = '{elem_type'(32'h80000000), 0, 0, 0, elem_type'(32'h80000000), 0, 0, 0,
            elem_type'(32'h80000000)};
      send_matrix(a);
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(a);
      a = '{one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, 1, 5, 9};
      send_matrix(a);
      a = '{2 * one, -one, 0, -one, 2 * one, -one, 0, -one, 2 * one};
      send_matrix(a);
      write_register(CSR_ORDER, ORDER_2);
      a = '{3 * one, one, elem_type'(32'hDEADBEEF), 2 * one, one, 7, -5, 9, 11};
      send_matrix(a);
      a = '{elem_type'(32'h7FFFFFFF), elem_type'(32'h80000000), 1, elem_type'(32'h80000000),
            elem_type'(32'h7FFFFFFF), 2, 3, 4, 5};
      send_matrix(a);
      a = '{one, 2 * one, -1, 2 * one, 4 * one, 1, 1, 1, 1};
      send_matrix(a);
      write_register(CSR_ORDER, ORDER_1);
      a = '{1, 9, 9, 9, 9, 9, 9, 9, 9};
      send_matrix(a);
      a = '{elem_type'(32'h80000000), 1, 2, 3, 4, 5, 6, 7, 8};
      send_matrix(a);
      a = '{-one, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(a);
      write_register(CSR_ORDER, ORDER_ZERO);
      a = '{elem_type'(32'h7FFFFFFF), 1, 1, 1, 1, 1, 1, 1, 1};
      send_matrix(a);
      write_register(CSR_THRESH, '0);
      a = '{0, 3, 3, 3, 3, 3, 3, 3, 3};
      send_matrix(a);
      write_register(CSR_SPARE, '1);
      write_register(CSR_ORDER, ORDER_3);
      write_register(CSR_THRESH, 1);
   endtask

   task automatic test_orders();
      write_register(CSR_ORDER, ORDER_3);
      send_random(250);
      write_register(CSR_ORDER, ORDER_2);
      send_random(180);
      write_register(CSR_ORDER, ORDER_1);
      send_random(120);
      write_register(CSR_ORDER, ORDER_ZERO);
      send_random(80);
   endtask

   task automatic test_thresholds();
      write_register(CSR_ORDER, ORDER_3);
      write_register(CSR_THRESH, '1);
      send_random(80);
      write_register(CSR_THRESH, '0);
      send_random(80);
      write_register(CSR_ORDER, ORDER_2);
      write_register(CSR_THRESH, 48'h1_0000_0000);
      send_random(80);
      write_register(CSR_ORDER, ORDER_1);
      write_register(CSR_THRESH, 48'h0000_0001_0000);
      send_random(60);
      write_register(CSR_ORDER, ORDER_3);
      write_register(CSR_THRESH, 48'({$urandom, $urandom}));
      send_random(60);
   endtask

   task automatic test_full_rate();
      write_register(CSR_THRESH, 1);
      quiet = 1;
      send_random(100);
      quiet = 0;
      send_random(60);
   endtask

   initial begin
      cur_order = ORDER_3;
      cur_thresh = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      test_orders();
      test_thresholds();
      test_full_rate();
      drain_results();
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && expected_inverses.size() == 0) begin
         $display("[small_matrix_inverse_unit] OK");
      end else begin
         $display("[small_matrix_inverse_unit] ERROR");
      end
      $finish;
   end
endmodule
